/* sv/lli_pkg.sv */
// Shared constants and types of the table interpolator.
package lli_pkg;

    localparam int TABLE_DEPTH = 256;
    localparam int INDEX_W     = $clog2(TABLE_DEPTH);
    localparam int SIZE_W      = 9;
    localparam int LOAD_IDX_W  = 8;
    localparam int VALUE_W     = 24;
    localparam int SAMPLE_W    = 18;
    localparam int FRAC_W      = 16;
    // compare width wide enough for the size register and the table depth
    localparam int CMP_W       = ((INDEX_W > SIZE_W) ? INDEX_W : SIZE_W) + 2;
    // signed product of sample and span
    localparam int POS_W       = SAMPLE_W + INDEX_W + 1;
    localparam int QUEUE_DEPTH = 4;
    localparam int QPTR_W      = $clog2(QUEUE_DEPTH);

    localparam logic FUNC_LOAD = 1'b0;
    localparam logic FUNC_MAP  = 1'b1;

    // one classified item on its way to the table side
    typedef struct packed {
        logic                 is_map;
        logic [INDEX_W-1:0]   addr;
        logic [FRAC_W-1:0]    frac;
        logic [VALUE_W-1:0]   value;
        logic                 last;
    } op_t;

    typedef struct packed {
        logic              push;
        logic              pop;
        logic [QPTR_W:0]   count;
    } queue_status_t;

endpackage

/* sv/lli_front.sv */
// Front end: size register, sample scaling and item classification.
module lli_front (
    input  logic                             aclk,
    input  logic                             aresetn,
    input  logic                             cfg_valid,
    output logic                             cfg_ready,
    input  logic [lli_pkg::SIZE_W-1:0]       cfg_table_size,
    input  logic                             s_valid,
    output logic                             s_ready,
    input  logic                             s_func,
    input  logic [lli_pkg::LOAD_IDX_W-1:0]   s_entry_index,
    input  logic signed [lli_pkg::VALUE_W-1:0]  s_entry_value,
    input  logic signed [lli_pkg::SAMPLE_W-1:0] s_sample,
    input  logic                             s_last_in,
    output logic                             q_valid,
    input  logic                             q_ready,
    output lli_pkg::op_t                     q_op,
    output logic [lli_pkg::INDEX_W-1:0]      span
);
    import lli_pkg::*;

    logic [INDEX_W-1:0]         span_reg, span_next;
    logic                       f_valid_reg, f_valid_next;
    logic                       f_func_reg;
    logic [LOAD_IDX_W-1:0]      f_idx_reg;
    logic [VALUE_W-1:0]         f_value_reg;
    logic                       f_last_reg;
    logic signed [POS_W-1:0]    f_pos_reg;

    logic [CMP_W-1:0]           size_w;
    logic signed [POS_W-1:0]    sample_ext, span_ext, pos_prod, end_pos;
    logic                       drop, take;

    assign cfg_ready = 1'b1;
    assign span      = span_reg;

    // span = clamped table size minus one
    assign size_w = CMP_W'(cfg_table_size);
    always_comb begin
        if (size_w < CMP_W'(2)) begin
            span_next = INDEX_W'(1);
        end else if (size_w > CMP_W'(TABLE_DEPTH)) begin
            span_next = INDEX_W'(TABLE_DEPTH - 1);
        end else begin
            span_next = INDEX_W'(size_w - CMP_W'(1));
        end
    end

    assign sample_ext = POS_W'(s_sample);
    assign span_ext   = POS_W'($signed({1'b0, span_reg}));
    assign pos_prod   = sample_ext * span_ext;

    // loads beyond the table are dropped here
    assign drop    = (f_func_reg == FUNC_LOAD) &&
                     (CMP_W'(f_idx_reg) >= CMP_W'(TABLE_DEPTH));
    assign q_valid = f_valid_reg && !drop;
    assign take    = !f_valid_reg || drop || q_ready;
    assign s_ready = take;

    always_comb begin
        f_valid_next = f_valid_reg;
        if (take) begin
            f_valid_next = s_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            span_reg    <= INDEX_W'(TABLE_DEPTH - 1);
            f_valid_reg <= 1'b0;
        end else begin
            f_valid_reg <= f_valid_next;
            if (cfg_valid) begin
                span_reg <= span_next;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (take && s_valid) begin
            f_func_reg  <= s_func;
            f_idx_reg   <= s_entry_index;
            f_value_reg <= s_entry_value;
            f_last_reg  <= s_last_in;
            f_pos_reg   <= pos_prod;
        end
    end

    // classification: clamp below, clamp at the end, else split index/fraction
    assign end_pos = POS_W'($signed({1'b0, span_reg, {FRAC_W{1'b0}}}));
    always_comb begin
        q_op.is_map = (f_func_reg == FUNC_MAP);
        q_op.value  = f_value_reg;
        q_op.last   = f_last_reg;
        q_op.frac   = '0;
        if (f_func_reg == FUNC_LOAD) begin
            q_op.addr = INDEX_W'(f_idx_reg);
        end else if (f_pos_reg <= 0) begin
            q_op.addr = '0;
        end else if (f_pos_reg >= end_pos) begin
            q_op.addr = span_reg;
        end else begin
            q_op.addr = f_pos_reg[FRAC_W +: INDEX_W];
            q_op.frac = f_pos_reg[FRAC_W-1:0];
        end
    end

endmodule

/* sv/lli_queue.sv */
// Short item queue between front and back ends.
module lli_queue (
    input  logic                   aclk,
    input  logic                   aresetn,
    input  logic                   in_valid,
    output logic                   in_ready,
    input  lli_pkg::op_t           in_op,
    output logic                   out_valid,
    input  logic                   out_ready,
    output lli_pkg::op_t           out_op,
    output lli_pkg::queue_status_t status
);
    import lli_pkg::*;

    op_t               slots [QUEUE_DEPTH];
    logic [QPTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [QPTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [QPTR_W:0]   count_reg, count_next;
    logic              push, pop;

    assign in_ready  = (count_reg != (QPTR_W+1)'(QUEUE_DEPTH));
    assign out_valid = (count_reg != '0);
    assign out_op    = slots[rd_ptr_reg];
    assign push      = in_valid && in_ready;
    assign pop       = out_valid && out_ready;

    always_comb begin
        wr_ptr_next = push ? wr_ptr_reg + QPTR_W'(1) : wr_ptr_reg;
        rd_ptr_next = pop  ? rd_ptr_reg + QPTR_W'(1) : rd_ptr_reg;
        count_next  = count_reg;
        if (push && !pop) begin
            count_next = count_reg + (QPTR_W+1)'(1);
        end else if (pop && !push) begin
            count_next = count_reg - (QPTR_W+1)'(1);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            slots[wr_ptr_reg] <= in_op;
        end
    end

    assign status.push  = push;
    assign status.pop   = pop;
    assign status.count = count_reg;

endmodule

/* sv/lli_back.sv */
// Back end: table memory, neighbour read, blend and output register.
module lli_back (
    input  logic                               aclk,
    input  logic                               aresetn,
    input  logic                               q_valid,
    output logic                               q_ready,
    input  lli_pkg::op_t                       q_op,
    output logic                               m_valid,
    input  logic                               m_ready,
    output logic signed [lli_pkg::VALUE_W-1:0] m_mapped,
    output logic                               m_last_out
);
    import lli_pkg::*;

    localparam int PROD_W = FRAC_W + VALUE_W + 2;

    logic [VALUE_W-1:0]        table_mem [TABLE_DEPTH];

    logic                      en, pop;
    logic [INDEX_W-1:0]        addr_b;

    logic                      r_valid_reg, r_valid_next;
    logic [FRAC_W-1:0]         r_frac_reg;
    logic                      r_last_reg;
    logic signed [VALUE_W-1:0] rd_a_reg, rd_b_reg;

    logic                      p_valid_reg, p_valid_next;
    logic                      p_last_reg;
    logic signed [VALUE_W-1:0] p_base_reg;
    logic signed [PROD_W-1:0]  p_prod_reg, prod;
    logic signed [VALUE_W:0]   diff;

    logic                      out_valid_reg, out_valid_next;
    logic [VALUE_W-1:0]        out_mapped_reg, out_mapped_next;
    logic                      out_last_reg;

    // whole pipe moves together; output register parts it from the sink
    assign en      = !out_valid_reg || m_ready;
    assign q_ready = en;
    assign pop     = q_valid && en;

    // zero fraction: second neighbour carries no weight, stay on the same entry
    assign addr_b = (q_op.frac == '0) ? q_op.addr : q_op.addr + INDEX_W'(1);

    always_ff @(posedge aclk) begin
        if (pop && !q_op.is_map) begin
            table_mem[q_op.addr] <= q_op.value;
        end
        if (en) begin
            rd_a_reg <= table_mem[q_op.addr];
            rd_b_reg <= table_mem[addr_b];
        end
    end

    // a + floor(f * (b - a) / 2^16)
    assign diff = (VALUE_W+1)'(rd_b_reg) - (VALUE_W+1)'(rd_a_reg);
    assign prod = PROD_W'($signed({1'b0, r_frac_reg})) * PROD_W'(diff);
    assign out_mapped_next = VALUE_W'(p_prod_reg >>> FRAC_W) + p_base_reg;

    always_comb begin
        r_valid_next   = r_valid_reg;
        p_valid_next   = p_valid_reg;
        out_valid_next = out_valid_reg;
        if (en) begin
            r_valid_next   = pop && q_op.is_map;
            p_valid_next   = r_valid_reg;
            out_valid_next = p_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            r_valid_reg   <= 1'b0;
            p_valid_reg   <= 1'b0;
            out_valid_reg <= 1'b0;
        end else begin
            r_valid_reg   <= r_valid_next;
            p_valid_reg   <= p_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            r_frac_reg     <= q_op.frac;
            r_last_reg     <= q_op.last;
            p_prod_reg     <= prod;
            p_base_reg     <= rd_a_reg;
            p_last_reg     <= r_last_reg;
            out_mapped_reg <= out_mapped_next;
            out_last_reg   <= p_last_reg;
        end
    end

    assign m_valid    = out_valid_reg;
    assign m_mapped   = out_mapped_reg;
    assign m_last_out = out_last_reg;

endmodule

/* sv/lut_linear_interpolator.sv */
// Top level of the table-driven linear interpolator.
// Remaps intensities through a loaded table of signed Q7.16 entries. A load item
// (func 0) writes one entry; a map item (func 1) scales its signed Q1.16 sample by
// (table_size - 1), splits the result into an entry index and a 16-bit fraction,
// and returns the floor-rounded blend of the two neighbouring entries, with the
// first entry at or below zero and the last entry at or past the end. Load items
// give no result; last_in of a map item comes back as last_out. Throughput is one
// item per clock in steady state while m_ready holds no result back. A map item
// passes five register stages before m_valid rises: the scaling multiplier
// (loaded at its accepting edge), the queue, the registered table read, the
// blend multiplier and the output register. The four-entry queue between the
// front end and the table side lets the input keep accepting while a result waits
// on m_ready. Entries must be loaded before a map item reads them; the table is
// not cleared at reset.
// table_size (2..256, reset 256, clamped) may be written only while idle.
module lut_linear_interpolator (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  logic                                cfg_valid,
    output logic                                cfg_ready,
    input  logic [lli_pkg::SIZE_W-1:0]          cfg_table_size,
    input  logic                                s_valid,
    output logic                                s_ready,
    input  logic                                s_func,
    input  logic [lli_pkg::LOAD_IDX_W-1:0]      s_entry_index,
    input  logic signed [lli_pkg::VALUE_W-1:0]  s_entry_value,
    input  logic signed [lli_pkg::SAMPLE_W-1:0] s_sample,
    input  logic                                s_last_in,
    output logic                                m_valid,
    input  logic                                m_ready,
    output logic signed [lli_pkg::VALUE_W-1:0]  m_mapped,
    output logic                                m_last_out
);
    import lli_pkg::*;

    logic          fq_valid, fq_ready;
    op_t           fq_op;
    logic          qb_valid, qb_ready;
    op_t           qb_op;
    queue_status_t q_status;
    logic [INDEX_W-1:0] span;

    // scaling and classification
    lli_front u_front (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .cfg_valid      (cfg_valid),
        .cfg_ready      (cfg_ready),
        .cfg_table_size (cfg_table_size),
        .s_valid        (s_valid),
        .s_ready        (s_ready),
        .s_func         (s_func),
        .s_entry_index  (s_entry_index),
        .s_entry_value  (s_entry_value),
        .s_sample       (s_sample),
        .s_last_in      (s_last_in),
        .q_valid        (fq_valid),
        .q_ready        (fq_ready),
        .q_op           (fq_op),
        .span           (span)
    );

    // decouples the two halves; loads and maps keep their order through it
    lli_queue u_queue (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (fq_valid),
        .in_ready  (fq_ready),
        .in_op     (fq_op),
        .out_valid (qb_valid),
        .out_ready (qb_ready),
        .out_op    (qb_op),
        .status    (q_status)
    );

    // table store and blend
    lli_back u_back (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .q_valid    (qb_valid),
        .q_ready    (qb_ready),
        .q_op       (qb_op),
        .m_valid    (m_valid),
        .m_ready    (m_ready),
        .m_mapped   (m_mapped),
        .m_last_out (m_last_out)
    );

    // queue fill stays within its depth
    a_queue_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        q_status.count <= (QPTR_W+1)'(QUEUE_DEPTH))
        else $error("queue count beyond depth");

    // count rises by one after a push without a pop
    a_queue_count: assert property (@(posedge aclk) disable iff (!aresetn)
        (q_status.push && !q_status.pop) |=>
            q_status.count == $past(q_status.count) + (QPTR_W+1)'(1))
        else $error("queue count lost a push");

    // span never collapses to zero, whatever size is written
    a_span_range: assert property (@(posedge aclk) disable iff (!aresetn)
        span != '0)
        else $error("table span is zero");

endmodule
